// File: rtl/core/mavg_pkg.sv
// moving average filter: shared types and fixed constants
// no dependencies; used by every module of the filter by scoped names
package mavg_pkg;

  // width of the window length register as seen on the configuration port
  localparam int unsigned CFG_BITS = 7;

  // window length after reset, clamped to the store depth where that is smaller
  localparam int unsigned WIN_RESET = 64;

  // depth of the queue of running sums between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // front end: read the old entry, then update the store and the running sum
  typedef enum logic {
    FR_IDLE,
    FR_UPD
  } fr_state_e;

  // back end: take a sum, divide bit by bit, hold the average
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_HOLD
  } bk_state_e;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// File: rtl/core/mavg_queue.sv
// moving average filter: short queue of running sums between front and back
// depends on mavg_pkg (depth constant and status struct)
module mavg_queue #(
  parameter int unsigned DATA_W = 22
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clr_i,
  input  logic                  push_i,
  input  logic [DATA_W-1:0]     push_data_i,
  input  logic                  pop_i,
  output logic [DATA_W-1:0]     pop_data_o,
  output mavg_pkg::queue_stat_t stat_o
);

  localparam int unsigned Depth = mavg_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [DATA_W-1:0] slot_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
    if (clr_i) begin
      wr_ptr_d = '0;
      rd_ptr_d = '0;
      cnt_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o   = slot_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);

  // checks
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("queue pushed while full");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("queue popped while empty");

endmodule

// File: rtl/core/mavg_front.sv
// moving average filter: front end, sample ring store and running window sum
// depends on mavg_pkg (state enum, queue status struct)
module mavg_front #(
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned WIN_W       = 7,
  parameter int unsigned SUM_W       = 22
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clr_i,
  input  logic [WIN_W-1:0]         win_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [SAMPLE_BITS-1:0]   sample_i,
  input  mavg_pkg::queue_stat_t    q_stat_i,
  output logic                     push_o,
  output logic [SUM_W-1:0]         push_sum_o
);

  localparam int unsigned PosW = $clog2(MAX_WINDOW);

  mavg_pkg::fr_state_e st_q, st_d;

  logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]  vld_q;
  logic [SAMPLE_BITS-1:0] rdata_q;
  logic [SAMPLE_BITS-1:0] samp_q;
  logic [PosW-1:0]        pos_q;
  logic [WIN_W-1:0]       pos_inc;
  logic [SUM_W-1:0]       sum_q;
  logic [SAMPLE_BITS-1:0] old_samp;
  logic [SUM_W-1:0]       sum_nx;
  logic                   accept;
  logic                   commit;

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      mavg_pkg::FR_IDLE: if (in_valid_i) st_d = mavg_pkg::FR_UPD;
      mavg_pkg::FR_UPD:  if (!q_stat_i.full) st_d = mavg_pkg::FR_IDLE;
      default:           st_d = mavg_pkg::FR_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready_o = 1'b0;
    push_o     = 1'b0;
    unique case (st_q)
      mavg_pkg::FR_IDLE: in_ready_o = 1'b1;
      mavg_pkg::FR_UPD:  push_o     = !q_stat_i.full;
      default:           in_ready_o = 1'b0;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;
  assign commit = push_o;

  // running sum: add the new sample, drop the one it overwrites
  assign old_samp = vld_q[pos_q] ? rdata_q : '0;
  assign sum_nx   = sum_q
                  + {{(SUM_W - SAMPLE_BITS){samp_q[SAMPLE_BITS-1]}}, samp_q}
                  - {{(SUM_W - SAMPLE_BITS){old_samp[SAMPLE_BITS-1]}}, old_samp};
  assign push_sum_o = sum_nx;

  // position wraps at the window length
  assign pos_inc = WIN_W'(pos_q) + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= mavg_pkg::FR_IDLE;
      vld_q <= '0;
      pos_q <= '0;
      sum_q <= '0;
    end else begin
      st_q <= st_d;
      if (clr_i) begin
        vld_q <= '0;
        pos_q <= '0;
        sum_q <= '0;
      end else if (commit) begin
        vld_q[pos_q] <= 1'b1;
        sum_q        <= sum_nx;
        pos_q        <= (pos_inc >= win_i) ? '0 : PosW'(pos_inc);
      end
    end
  end

  // sample store, read on acceptance and written on commit
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q <= mem[pos_q];
      samp_q  <= sample_i;
    end
    if (commit) begin
      mem[pos_q] <= samp_q;
    end
  end

  // checks
  a_pos_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WIN_W'(pos_q) < win_i)
    else $error("write position outside window");

endmodule

// File: rtl/core/mavg_back.sv
// moving average filter: back end, signed sum divided by window length
// restoring division, one quotient bit per cycle; depends on mavg_pkg
module mavg_back #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned WIN_W       = 7,
  parameter int unsigned SUM_W       = 22
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [WIN_W-1:0]        win_i,
  input  mavg_pkg::queue_stat_t   q_stat_i,
  output logic                    pop_o,
  input  logic [SUM_W-1:0]        pop_sum_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [SAMPLE_BITS-1:0]  avg_o
);

  localparam int unsigned RemW = WIN_W + 1;
  localparam int unsigned CntW = $clog2(SUM_W + 1);

  mavg_pkg::bk_state_e st_q, st_d;

  logic [SUM_W-1:0]       dvd_q, dvd_d;
  logic [RemW-1:0]        rem_q, rem_d;
  logic [CntW-1:0]        cnt_q;
  logic                   neg_q;
  logic [SAMPLE_BITS-1:0] avg_q;
  logic [RemW-1:0]        trial;
  logic                   qbit;
  logic                   last_step;

  assign last_step = (cnt_q == CntW'(1));

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      mavg_pkg::BK_IDLE: if (!q_stat_i.empty) st_d = mavg_pkg::BK_DIV;
      mavg_pkg::BK_DIV:  if (last_step) st_d = mavg_pkg::BK_HOLD;
      mavg_pkg::BK_HOLD: if (out_ready_i) st_d = mavg_pkg::BK_IDLE;
      default:           st_d = mavg_pkg::BK_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    pop_o       = 1'b0;
    out_valid_o = 1'b0;
    unique case (st_q)
      mavg_pkg::BK_IDLE: pop_o       = !q_stat_i.empty;
      mavg_pkg::BK_HOLD: out_valid_o = 1'b1;
      default:           pop_o       = 1'b0;
    endcase
  end

  // one restoring step
  assign trial = {rem_q[RemW-2:0], dvd_q[SUM_W-1]};
  assign qbit  = (trial >= {1'b0, win_i});
  assign rem_d = qbit ? (trial - {1'b0, win_i}) : trial;
  assign dvd_d = {dvd_q[SUM_W-2:0], qbit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= mavg_pkg::BK_IDLE;
      cnt_q <= '0;
    end else begin
      st_q <= st_d;
      if (pop_o) begin
        cnt_q <= CntW'(SUM_W);
      end else if (st_q == mavg_pkg::BK_DIV) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // divider datapath; the quotient is at most half the sample range, so its
  // low bits give the two's complement average after the sign is restored
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      neg_q <= pop_sum_i[SUM_W-1];
      dvd_q <= pop_sum_i[SUM_W-1] ? (~pop_sum_i + 1'b1) : pop_sum_i;
      rem_q <= '0;
    end else if (st_q == mavg_pkg::BK_DIV) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
      if (last_step) begin
        avg_q <= neg_q ? (~dvd_d[SAMPLE_BITS-1:0] + 1'b1) : dvd_d[SAMPLE_BITS-1:0];
      end
    end
  end

  assign avg_o = avg_q;

  // checks
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == mavg_pkg::BK_DIV) |-> (win_i != '0))
    else $error("division by zero window");
  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == mavg_pkg::BK_DIV) |-> (cnt_q != '0))
    else $error("divider running with no steps left");

endmodule

// File: rtl/core/moving_average_filter_top.sv
// moving average filter: top level with window register and stream ports
// depends on mavg_pkg, mavg_front, mavg_queue and mavg_back
//
// Simple moving average over the last window_length samples (1 to MAX_WINDOW).
// Each accepted sample goes into a ring store and updates a running sum; the
// result is that sum divided by the window length, truncated toward zero.
// The front end reads the store on acceptance, then writes the store and
// updates the sum, waiting there while the queue is full; the back end
// divides with a restoring divider that yields one quotient bit per cycle,
// over the SUM_W = SAMPLE_BITS + clog2(MAX_WINDOW) bits of each sum. The
// divider sets the sustained rate; a two-entry queue of sums between the two
// ends lets the input keep moving while a result waits on the output. A write
// on the configuration channel sets the window (zero is taken as 1, values
// above MAX_WINDOW as MAX_WINDOW) and clears the store, position and sum in
// the same cycle; it is meant to be issued only while the filter is idle.
module moving_average_filter_top #(
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input samples; tdata: sample [SAMPLE_BITS-1:0], zero padded to bytes
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata_i,
  // averages; tdata: average [SAMPLE_BITS-1:0], zero padded to bytes
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata_o,
  // window length register write
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mavg_pkg::CFG_BITS-1:0]       cfg_data_i
);

  localparam int unsigned TdataW   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned WinW     = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SumW     = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int unsigned WinReset = (mavg_pkg::WIN_RESET > MAX_WINDOW) ?
                                     MAX_WINDOW : mavg_pkg::WIN_RESET;

  logic [WinW-1:0]        win_q, win_d;
  logic [31:0]            cfg_ext;
  logic                   cfg_wr;
  logic                   push;
  logic [SumW-1:0]        push_sum;
  logic                   pop;
  logic [SumW-1:0]        pop_sum;
  mavg_pkg::queue_stat_t  q_stat;
  logic [SAMPLE_BITS-1:0] avg;

  // window register with clamping
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign cfg_ext     = 32'(cfg_data_i);

  always_comb begin
    priority if (cfg_ext == 32'd0) begin
      win_d = WinW'(1);
    end else if (cfg_ext > 32'(MAX_WINDOW)) begin
      win_d = WinW'(MAX_WINDOW);
    end else begin
      win_d = WinW'(cfg_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WinW'(WinReset);
    end else if (cfg_wr) begin
      win_q <= win_d;
    end
  end

  // front end: store and running sum
  mavg_front #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .WIN_W       (WinW),
    .SUM_W       (SumW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (cfg_wr),
    .win_i      (win_q),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sample_i   (s_axis_tdata_i[SAMPLE_BITS-1:0]),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .push_sum_o (push_sum)
  );

  // queue of sums
  mavg_queue #(
    .DATA_W (SumW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (cfg_wr),
    .push_i      (push),
    .push_data_i (push_sum),
    .pop_i       (pop),
    .pop_data_o  (pop_sum),
    .stat_o      (q_stat)
  );

  // back end: divider and output register
  mavg_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .WIN_W       (WinW),
    .SUM_W       (SumW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .win_i       (win_q),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .pop_sum_i   (pop_sum),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .avg_o       (avg)
  );

  assign m_axis_tdata_o = TdataW'(avg);

  // checks
  a_win_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (win_q != '0) && (win_q <= WinW'(MAX_WINDOW)))
    else $error("window length out of range");
  a_win_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> (win_q == $past(win_d)))
    else $error("window register not loaded on write");

endmodule

// File: dv/moving_average_filter_top_tb.sv
// self-checking testbench for the moving average filter top level
// depends on mavg_pkg and moving_average_filter_top; a built-in window predictor
// checks every average against samples driven in random bursts and window settings
module moving_average_filter_top_tb;

  localparam int unsigned WIN_MAX     = 64;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned DRAIN_WAIT  = 64;

  // receiver stall patterns and sample mixes
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;
  typedef enum int {MIX_ANY, MIX_EDGES, MIX_TOP, MIX_BOTTOM, MIX_TINY} mix_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                          s_valid   = 1'b0;
  logic [SAMPLE_W-1:0]           s_data    = '0;
  logic                          m_ready   = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic [mavg_pkg::CFG_BITS-1:0] cfg_data  = '0;
  logic                          s_ready;
  logic                          m_valid;
  logic [SAMPLE_W-1:0]           m_data;
  logic                          cfg_ready;

  // predictor state: ring of recent samples, write position, window length
  logic signed [SAMPLE_W-1:0] ring_store [WIN_MAX];
  int unsigned                ring_pos;
  int unsigned                win_len;

  logic [SAMPLE_W-1:0] samples_to_send [$];
  logic [SAMPLE_W-1:0] averages_due [$];

  int       burst_left   = 1;
  int       gap_left     = 0;
  rx_mode_e rx_mode      = RX_OPEN;
  int       rx_left      = 0;
  int       rx_tick      = 0;
  int       quiet_cycles = 0;
  int       mismatches   = 0;

  moving_average_filter_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // new window length: zero means one, anything above the depth means the depth
  function automatic void set_window(logic [mavg_pkg::CFG_BITS-1:0] code);
    win_len = (code == 0) ? 1 : ((code > WIN_MAX) ? WIN_MAX : code);
    foreach (ring_store[i]) ring_store[i] = '0;
    ring_pos = 0;
  endfunction

  // store one sample in the ring and return the truncated window average
  function automatic logic [SAMPLE_W-1:0] fold_sample(logic [SAMPLE_W-1:0] sample);
    int total;
    int avg;
    total = 0;
    if (ring_pos >= win_len) ring_pos = 0;
    ring_store[ring_pos] = sample;
    ring_pos = ring_pos + 1;
    if (ring_pos >= win_len) ring_pos = 0;
    for (int i = 0; i < win_len; i++) total += int'(ring_store[i]);
    avg = total / int'(win_len);
    return avg[SAMPLE_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(mix_e mix);
    case (mix)
      MIX_EDGES:  return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      MIX_TOP:    return ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'h7FFF;
      MIX_BOTTOM: return ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'h8000;
      MIX_TINY:   return 16'(int'($urandom_range(0, 8)) - 4);
      default:    return 16'($urandom);
    endcase
  endfunction

  // quiet point: nothing queued, nothing in flight, every average back
  task automatic wait_idle();
    do @(negedge clk_i);
    while (samples_to_send.size() != 0 || s_valid || averages_due.size() != 0);
  endtask

  task automatic write_window(input logic [mavg_pkg::CFG_BITS-1:0] code);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= code;
    do @(posedge clk_i);
    while (!cfg_ready);
    set_window(code);
    cfg_valid <= 1'b0;
  endtask

  // sample driver: bursts of random length separated by random gaps
  always @(posedge clk_i) begin : sample_driver
    logic                taken;
    logic                next_valid;
    logic [SAMPLE_W-1:0] next_data;
    if (rst_ni) begin
      taken      = s_valid && s_ready;
      next_valid = s_valid && !taken;
      next_data  = s_data;
      if (taken) averages_due.push_back(fold_sample(s_data));
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (samples_to_send.size() > 0) begin
          next_valid = 1'b1;
          next_data  = samples_to_send.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            if ($urandom_range(0, 3) == 0) begin
              burst_left = $urandom_range(20, 64);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 12);
              gap_left   = $urandom_range(1, 15);
            end
          end
        end
      end
      s_valid <= next_valid;
      s_data  <= next_data;
    end
  end

  // receiver back-pressure, switching between patterns
  always @(posedge clk_i) begin : ready_pattern
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 160);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:   m_ready <= 1'b1;
      RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_ready <= ($urandom_range(0, 7) == 0);
      default:   m_ready <= ((rx_tick % 5) < 2);
    endcase
    rx_tick++;
  end

  // average checker against the oldest prediction
  always @(posedge clk_i) begin : average_monitor
    logic [SAMPLE_W-1:0] want;
    if (rst_ni && m_valid && m_ready) begin
      if (averages_due.size() == 0) begin
        $display("%0t: unexpected average, expected none, actual %0d",
                 $time, $signed(m_data));
        mismatches++;
      end else begin
        want = averages_due.pop_front();
        if (m_data !== want) begin
          $display("%0t: average mismatch, expected %0d, actual %0d",
                   $time, $signed(want), $signed(m_data));
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk_i) begin : stall_watchdog
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // stimulus sequence
  initial begin
    logic [SAMPLE_W-1:0] opening [10] = '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF,
                                          16'h0000, 16'h0001, 16'h5555, 16'hAAAA, 16'hFFFF};
    logic [SAMPLE_W-1:0] single [4] = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001};
    logic [SAMPLE_W-1:0] short_win [5] = '{16'hFFFF, 16'hFFFF, 16'hFFFE, 16'h0001, 16'h7FFF};
    logic [mavg_pkg::CFG_BITS-1:0] code;
    mix_e mix;
    int   n;

    set_window(mavg_pkg::CFG_BITS'(mavg_pkg::WIN_RESET));
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset window, field extremes and bit patterns
    @(negedge clk_i);
    foreach (opening[i]) samples_to_send.push_back(opening[i]);
    wait_idle();

    // window written as zero behaves as one
    write_window(7'd0);
    @(negedge clk_i);
    foreach (single[i]) samples_to_send.push_back(single[i]);
    wait_idle();

    // window above the depth is clamped, most negative sums
    write_window(7'd127);
    @(negedge clk_i);
    repeat (5) samples_to_send.push_back(16'h8000);
    wait_idle();

    // short window, truncation of negative sums toward zero
    write_window(7'd3);
    @(negedge clk_i);
    foreach (short_win[i]) samples_to_send.push_back(short_win[i]);
    wait_idle();

    // random phases over window settings
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0:       code = 7'd1;
        1:       code = 7'd64;
        2:       code = 7'd2;
        3:       code = 7'd65;
        4:       code = 7'd0;
        5:       code = 7'd63;
        6:       code = 7'd127;
        default: code = 7'($urandom_range(0, 127));
      endcase
      write_window(code);
      if (phase == 1) mix = MIX_TOP;
      else if (phase == 6) mix = MIX_BOTTOM;
      else mix = mix_e'($urandom_range(0, 4));
      n = (win_len >= 48) ? 68 : 24;
      @(negedge clk_i);
      repeat (n) samples_to_send.push_back(pick_sample(mix));
      wait_idle();
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
